FILE: rtl/tgfw_pkg.sv
// shared widths, codes and the 5x7 font for the text glyph framebuffer writer
package tgfw_pkg;

    // field widths
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int PIX_W   = 9;
    localparam int BIDX_W  = 10;
    localparam int STAT_W  = 2;
    localparam int DATA_W  = 8;
    localparam int CUR_W   = 11;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 5;
    localparam int GLYPH_W = 40;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_GLYPH   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEWLINE = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STAT_W-1:0] ST_OTHER   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_REGION_X = 3'd0;
    localparam logic [2:0] REG_REGION_Y = 3'd1;
    localparam logic [2:0] REG_REGION_W = 3'd2;
    localparam logic [2:0] REG_REGION_H = 3'd3;
    localparam logic [2:0] REG_INK_ON   = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0a;

    // pack five glyph columns, column 0 in the low byte
    function automatic logic [GLYPH_W-1:0] g5(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3,
                                              input logic [7:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    // glyph lookup with lower case folded to upper case, blank for unknown codes
    function automatic logic [GLYPH_W-1:0] font_glyph(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c_up;
        logic [GLYPH_W-1:0] g;
        c_up = code;
        if (code >= 8'h61 && code <= 8'h7a)
        begin
            c_up = code - 8'd32;
        end
        unique case (c_up)
            8'h30: g = g5(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e);
            8'h31: g = g5(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00);
            8'h32: g = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33: g = g5(8'h21, 8'h41, 8'h45, 8'h4b, 8'h31);
            8'h34: g = g5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10);
            8'h35: g = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g = g5(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30);
            8'h37: g = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e);
            8'h41: g = g5(8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e);
            8'h42: g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = g5(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c);
            8'h45: g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = g5(8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a);
            8'h48: g = g5(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f);
            8'h49: g = g5(8'h00, 8'h41, 8'h7f, 8'h41, 8'h00);
            8'h4a: g = g5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01);
            8'h4b: g = g5(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4c: g = g5(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4d: g = g5(8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f);
            8'h4e: g = g5(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f);
            8'h4f: g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e);
            8'h50: g = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = g5(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e);
            8'h52: g = g5(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = g5(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01);
            8'h55: g = g5(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f);
            8'h56: g = g5(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f);
            8'h57: g = g5(8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f);
            8'h58: g = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = g5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h5a: g = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            8'h2e: g = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h3a: g = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h25: g = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
            8'h2d, 8'h5f: g = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2f: g = g5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/tgfw_req_if.sv
// request channel: one item per transfer
interface tgfw_req_if;
    logic                               valid;
    logic                               ready;
    logic [tgfw_pkg::KIND_W-1:0]        kind;
    logic [tgfw_pkg::CHAR_W-1:0]        char_code;
    logic                               text_start;
    logic signed [tgfw_pkg::PIX_W-1:0]  pixel_x;
    logic signed [tgfw_pkg::PIX_W-1:0]  pixel_y;
    logic                               pixel_on;
    logic [tgfw_pkg::BIDX_W-1:0]        byte_index;

    modport source (output valid, kind, char_code, text_start, pixel_x, pixel_y, pixel_on,
                    byte_index, input ready);
    modport sink (input valid, kind, char_code, text_start, pixel_x, pixel_y, pixel_on,
                  byte_index, output ready);
endinterface

FILE: rtl/tgfw_rsp_if.sv
// response channel: one result per transfer
interface tgfw_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tgfw_pkg::STAT_W-1:0]        status;
    logic [tgfw_pkg::DATA_W-1:0]        read_data;
    logic signed [tgfw_pkg::CUR_W-1:0]  cursor_col;
    logic signed [tgfw_pkg::CUR_W-1:0]  cursor_row;

    modport source (output valid, status, read_data, cursor_col, cursor_row, input ready);
    modport sink (input valid, status, read_data, cursor_col, cursor_row, output ready);
endinterface

FILE: rtl/text_glyph_framebuffer_writer_unit.sv
// text glyph framebuffer writer: page-organized monochrome framebuffer with 5x7 text
//
// Items arrive on req (valid/ready); each gives one result on rsp (valid/ready).
// Registers region_x/y/w/h and ink_on sit on an APB-style port at 4*index; pready
// is tied high and a write lands at psel & penable & pwrite.
// The block takes one item at a time; req.ready is high only while it is idle.
// Steps from transfer to result:
//   text character: the wrap and region checks, then, unless it is a newline or
//   ignored, a read and a write for each of the ten framebuffer bytes a glyph can
//   touch; bytes that are clipped or receive no glyph bits get no read or write
//   pixel write: a read and a write, none if clipped; byte read: a registered read;
//   clear: a clearing pass as after reset
// The framebuffer is one single-port-style memory with a registered read; every
// read-modify-write goes through it one byte at a time. After reset a clearing
// pass writes zero to all SCREEN_WIDTH*pages bytes, one per cycle (1024 bytes at
// the default size); no item is taken meanwhile, but register writes are. A result
// waits in an output register while rsp stalls; the block may take the next item
// meanwhile and holds its result until the register frees up.
module text_glyph_framebuffer_writer_unit #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tgfw_req_if.sink                        req,
    tgfw_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgfw_pkg::PADDR_W-1:0]    paddr,
    input  logic [tgfw_pkg::APB_DW-1:0]     pwdata,
    output logic [tgfw_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import tgfw_pkg::*;

    localparam int FB_PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES  = SCREEN_WIDTH * FB_PAGES;
    localparam int ADDR_W    = $clog2(FB_BYTES);
    localparam int PAGE_W    = (FB_PAGES > 1) ? $clog2(FB_PAGES) : 1;
    localparam int XW        = $clog2(SCREEN_WIDTH);
    localparam int LAST_ROWS = SCREEN_HEIGHT - 8 * (FB_PAGES - 1);
    localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FB_BYTES - 1);

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_CHK2 = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // control state
    logic [2:0]                 state_reg, state_next;
    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                       clr_reply_reg, clr_reply_next;
    logic signed [PIX_W-1:0]    region_x_reg, region_x_next;
    logic signed [PIX_W-1:0]    region_y_reg, region_y_next;
    logic [7:0]                 region_w_reg, region_w_next;
    logic [7:0]                 region_h_reg, region_h_next;
    logic                       ink_on_reg, ink_on_next;
    logic signed [CUR_W-1:0]    text_col_reg, text_col_next;
    logic signed [CUR_W-1:0]    text_row_reg, text_row_next;
    logic                       halted_reg, halted_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic [2:0]                 col_cnt_reg, col_cnt_next;
    logic                       half_reg, half_next;
    logic                       out_valid_reg, out_valid_next;

    // payload state
    logic [GLYPH_W-1:0]         glyph_reg, glyph_next;
    logic                       nl_reg, nl_next;
    logic signed [PIX_W-1:0]    px_reg, px_next;
    logic signed [PIX_W-1:0]    py_reg, py_next;
    logic                       op_ink_reg, op_ink_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [7:0]                 mask_reg, mask_next;
    logic [STAT_W-1:0]          status_reg, status_next;
    logic [STAT_W-1:0]          out_status_reg, out_status_next;
    logic [DATA_W-1:0]          out_data_reg, out_data_next;
    logic signed [CUR_W-1:0]    out_col_reg, out_col_next;
    logic signed [CUR_W-1:0]    out_row_reg, out_row_next;

    // framebuffer memory
    logic [7:0]                 fb_mem [FB_BYTES];
    logic [7:0]                 rdata_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [7:0]                 mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    logic                       rd_en;

    // text bounds
    logic signed [12:0]         row_p7, bottom, col_p5, right_edge;
    logic                       row_full, col_full;

    // byte step datapath
    logic signed [11:0]         x_t;
    logic signed [8:0]          pg_t;
    logic [7:0]                 gcol;
    logic [15:0]                gshift;
    logic [7:0]                 mask_t, mask_p, mask_sel;
    logic                       hit_t, hit_p, hit;
    logic [XW-1:0]              x_sel;
    logic [PAGE_W-1:0]          pg_sel;
    logic [ADDR_W-1:0]          addr_calc;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register read mux
    always_comb
    begin
        unique case (paddr[4:2])
            REG_REGION_X: prdata = APB_DW'(region_x_reg);
            REG_REGION_Y: prdata = APB_DW'(region_y_reg);
            REG_REGION_W: prdata = APB_DW'(region_w_reg);
            REG_REGION_H: prdata = APB_DW'(region_h_reg);
            REG_INK_ON:   prdata = APB_DW'(ink_on_reg);
            default:      prdata = '0;
        endcase
    end

    // region compares on the current cursor
    assign row_p7     = 13'(text_row_reg) + 13'sd7;
    assign bottom     = 13'(region_y_reg) + $signed({5'b0, region_h_reg});
    assign col_p5     = 13'(text_col_reg) + 13'sd5;
    assign right_edge = 13'(region_x_reg) + $signed({5'b0, region_w_reg});
    assign row_full   = row_p7 >= bottom;
    assign col_full   = col_p5 >= right_edge;

    // text byte: glyph column shifted into one of two pages
    assign x_t    = 12'(text_col_reg) + $signed({9'b0, col_cnt_reg});
    assign pg_t   = 9'(text_row_reg >>> 3) + $signed({8'b0, half_reg});
    assign gcol   = glyph_reg[{col_cnt_reg, 3'b000} +: 8];
    assign gshift = {8'b0, gcol} << text_row_reg[2:0];

    always_comb
    begin
        mask_t = half_reg ? gshift[15:8] : gshift[7:0];
        if (pg_t == $signed(9'(FB_PAGES - 1)))
        begin
            mask_t = mask_t & LAST_MASK;
        end
    end

    assign hit_t = !x_t[11] && (x_t < $signed(12'(SCREEN_WIDTH)))
                   && !pg_t[8] && (pg_t < $signed(9'(FB_PAGES))) && (mask_t != 8'd0);

    // pixel byte
    assign mask_p = 8'd1 << py_reg[2:0];
    assign hit_p  = !px_reg[8] && ({1'b0, px_reg[7:0]} < 9'(SCREEN_WIDTH))
                    && !py_reg[8] && ({1'b0, py_reg[7:0]} < 9'(SCREEN_HEIGHT));

    // shared address unit: page * width + column
    assign x_sel     = (kind_reg == KIND_TEXT) ? x_t[XW-1:0] : px_reg[XW-1:0];
    assign pg_sel    = (kind_reg == KIND_TEXT) ? pg_t[PAGE_W-1:0] : py_reg[PAGE_W+2:3];
    assign mask_sel  = (kind_reg == KIND_TEXT) ? mask_t : mask_p;
    assign hit       = (kind_reg == KIND_TEXT) ? hit_t : hit_p;
    assign addr_calc = ADDR_W'(ADDR_W'(pg_sel) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(x_sel);

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        region_x_next   = region_x_reg;
        region_y_next   = region_y_reg;
        region_w_next   = region_w_reg;
        region_h_next   = region_h_reg;
        ink_on_next     = ink_on_reg;
        text_col_next   = text_col_reg;
        text_row_next   = text_row_reg;
        halted_next     = halted_reg;
        kind_next       = kind_reg;
        col_cnt_next    = col_cnt_reg;
        half_next       = half_reg;
        out_valid_next  = out_valid_reg;
        glyph_next      = glyph_reg;
        nl_next         = nl_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        op_ink_next     = op_ink_reg;
        rd_ok_next      = rd_ok_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = '0;
        mem_raddr       = addr_calc;
        rd_en           = 1'b0;
        req.ready       = (state_reg == S_IDLE);

        // register writes
        if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_REGION_X: region_x_next = pwdata[PIX_W-1:0];
                REG_REGION_Y: region_y_next = pwdata[PIX_W-1:0];
                REG_REGION_W: region_w_next = pwdata[7:0];
                REG_REGION_H: region_h_next = pwdata[7:0];
                REG_INK_ON:   ink_on_next   = pwdata[0];
                default:      ink_on_next   = ink_on_reg;
            endcase
        end

        // result register drains on a transfer
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next   = '0;
                    clr_reply_next = 1'b0;
                    state_next     = clr_reply_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                mem_raddr = ADDR_W'(req.byte_index);
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    glyph_next  = font_glyph(req.char_code);
                    nl_next     = (req.char_code == CHAR_NL);
                    px_next     = req.pixel_x;
                    py_next     = req.pixel_y;
                    rd_ok_next  = (req.kind == KIND_READ)
                                  && (12'(req.byte_index) < 12'(FB_BYTES));
                    status_next = ST_OTHER;
                    unique case (req.kind)
                        KIND_TEXT:
                        begin
                            if (req.text_start)
                            begin
                                text_col_next = 11'(region_x_reg);
                                text_row_next = 11'(region_y_reg);
                                halted_next   = 1'b0;
                            end
                            state_next = S_CHK;
                        end
                        KIND_PIXEL:
                        begin
                            op_ink_next = req.pixel_on;
                            state_next  = S_RD;
                        end
                        KIND_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            clr_reply_next = 1'b1;
                            clr_cnt_next   = '0;
                            state_next     = S_CLR;
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                priority if (halted_reg || row_full)
                begin
                    halted_next = 1'b1;
                    status_next = ST_IGNORED;
                    state_next  = S_FIN;
                end
                else if (nl_reg || col_full)
                begin
                    text_col_next = 11'(region_x_reg);
                    text_row_next = text_row_reg + 11'sd8;
                    if (nl_reg)
                    begin
                        status_next = ST_NEWLINE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_CHK2;
                    end
                end
                else
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (row_full)
                begin
                    halted_next = 1'b1;
                    status_next = ST_IGNORED;
                    state_next  = S_FIN;
                end
                else
                begin
                    col_cnt_next = '0;
                    half_next    = 1'b0;
                    op_ink_next  = ink_on_reg;
                    state_next   = S_RD;
                end
            end
            S_RD, S_WR:
            begin
                // read phase fetches the byte, write phase merges the mask
                if (state_reg == S_RD && hit)
                begin
                    rd_en      = 1'b1;
                    addr_next  = addr_calc;
                    mask_next  = mask_sel;
                    state_next = S_WR;
                end
                else
                begin
                    if (state_reg == S_WR)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = op_ink_reg ? (rdata_reg | mask_reg)
                                               : (rdata_reg & ~mask_reg);
                    end
                    // step to the next byte or finish
                    priority if (kind_reg != KIND_TEXT)
                    begin
                        state_next = S_FIN;
                    end
                    else if (col_cnt_reg == 3'd4 && half_reg)
                    begin
                        text_col_next = text_col_reg + 11'sd6;
                        status_next   = ST_GLYPH;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        if (half_reg)
                        begin
                            col_cnt_next = col_cnt_reg + 3'd1;
                        end
                        half_next  = !half_reg;
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = rd_ok_reg ? rdata_reg : '0;
                    out_col_next    = text_col_reg;
                    out_row_next    = text_row_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            region_x_reg  <= '0;
            region_y_reg  <= '0;
            region_w_reg  <= 8'd128;
            region_h_reg  <= 8'd64;
            ink_on_reg    <= 1'b1;
            text_col_reg  <= '0;
            text_row_reg  <= '0;
            halted_reg    <= 1'b0;
            kind_reg      <= KIND_TEXT;
            col_cnt_reg   <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            region_x_reg  <= region_x_next;
            region_y_reg  <= region_y_next;
            region_w_reg  <= region_w_next;
            region_h_reg  <= region_h_next;
            ink_on_reg    <= ink_on_next;
            text_col_reg  <= text_col_next;
            text_row_reg  <= text_row_next;
            halted_reg    <= halted_next;
            kind_reg      <= kind_next;
            col_cnt_reg   <= col_cnt_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        glyph_reg      <= glyph_next;
        nl_reg         <= nl_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        op_ink_reg     <= op_ink_next;
        rd_ok_reg      <= rd_ok_next;
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
    end

    // framebuffer with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fb_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= fb_mem[mem_raddr];
        end
    end

    // response channel
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_we)
        else $error("framebuffer written while idle");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the finish step");

    a_clr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> clr_cnt_reg <= LAST_ADDR)
        else $error("clear counter beyond framebuffer");

    a_draw_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_WR) && kind_reg == KIND_TEXT
        |-> col_cnt_reg <= 3'd4)
        else $error("glyph column counter out of range");

    a_halt_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && state_reg == S_CHK |=> status_reg == ST_IGNORED && state_reg == S_FIN)
        else $error("halted text not ignored");
`endif

endmodule

FILE: dv/tb_text_glyph_framebuffer_writer_unit.sv
// testbench for the text glyph framebuffer writer: directed and random items checked against a shadow framebuffer
module tb_text_glyph_framebuffer_writer_unit;
    import tgfw_pkg::*;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int FB_BYTES      = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
    localparam int CHAR_STEP     = 6;
    localparam int LINE_STEP     = 8;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [CHAR_W-1:0]        char_code;
        logic                     text_start;
        logic signed [PIX_W-1:0]  pixel_x;
        logic signed [PIX_W-1:0]  pixel_y;
        logic                     pixel_on;
        logic [BIDX_W-1:0]        byte_index;
    } glyph_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [DATA_W-1:0]        read_data;
        logic signed [CUR_W-1:0]  cursor_col;
        logic signed [CUR_W-1:0]  cursor_row;
    } glyph_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    tgfw_req_if req_ch();
    tgfw_rsp_if rsp_ch();

    text_glyph_framebuffer_writer_unit #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block state and registers
    logic [7:0] shadow_fb [FB_BYTES];
    int         cur_col;
    int         cur_row;
    bit         text_halted;
    int         reg_rx;
    int         reg_ry;
    int         reg_rw;
    int         reg_rh;
    bit         reg_ink;

    glyph_result_t render_outcomes [$];

    int req_idle_pct;
    int rsp_idle_pct;
    int hold_left;
    int errors;
    int items_sent;
    int counted_items;
    int settings_applied;
    int n_glyph;
    int n_newline;
    int n_ignored;
    int n_other;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // 5x7 font, column 0 first, bit 0 is the top row
    function automatic logic [0:4][7:0] font_columns(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z")
        begin
            c = c - 8'd32;
        end
        case (c)
            "0": return {8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e};
            "1": return {8'h00, 8'h42, 8'h7f, 8'h40, 8'h00};
            "2": return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            "3": return {8'h21, 8'h41, 8'h45, 8'h4b, 8'h31};
            "4": return {8'h18, 8'h14, 8'h12, 8'h7f, 8'h10};
            "5": return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            "6": return {8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30};
            "7": return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            "8": return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            "9": return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1e};
            "A": return {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
            "B": return {8'h7f, 8'h49, 8'h49, 8'h49, 8'h36};
            "C": return {8'h3e, 8'h41, 8'h41, 8'h41, 8'h22};
            "D": return {8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c};
            "E": return {8'h7f, 8'h49, 8'h49, 8'h49, 8'h41};
            "F": return {8'h7f, 8'h09, 8'h09, 8'h09, 8'h01};
            "G": return {8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a};
            "H": return {8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f};
            "I": return {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
            "J": return {8'h20, 8'h40, 8'h41, 8'h3f, 8'h01};
            "K": return {8'h7f, 8'h08, 8'h14, 8'h22, 8'h41};
            "L": return {8'h7f, 8'h40, 8'h40, 8'h40, 8'h40};
            "M": return {8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f};
            "N": return {8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f};
            "O": return {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
            "P": return {8'h7f, 8'h09, 8'h09, 8'h09, 8'h06};
            "Q": return {8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e};
            "R": return {8'h7f, 8'h09, 8'h19, 8'h29, 8'h46};
            "S": return {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            "T": return {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
            "U": return {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
            "V": return {8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f};
            "W": return {8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f};
            "X": return {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            "Y": return {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            "Z": return {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            ".": return {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            ":": return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            "%": return {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
            "-", "_": return {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            "/": return {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
            default: return '0;
        endcase
    endfunction

    // cursor arithmetic wraps at 11 bits
    function automatic int wrap11(input int v);
        logic signed [CUR_W-1:0] t;
        t = v[CUR_W-1:0];
        return t;
    endfunction

    function automatic void set_pixel(input int x, input int y, input bit on);
        int idx;
        if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
        begin
            return;
        end
        idx = (y / 8) * SCREEN_WIDTH + x;
        shadow_fb[idx][y % 8] = on;
    endfunction

    // one text character against the cursor and region
    function automatic logic [STAT_W-1:0] advance_text(input logic [CHAR_W-1:0] c);
        int bottom;
        logic [0:4][7:0] cols;
        bottom = reg_ry + reg_rh;
        if (text_halted || cur_row + GLYPH_ROWS >= bottom)
        begin
            text_halted = 1'b1;
            return ST_IGNORED;
        end
        if (c == CHAR_NL || cur_col + GLYPH_COLS >= reg_rx + reg_rw)
        begin
            cur_col = reg_rx;
            cur_row = wrap11(cur_row + LINE_STEP);
            if (c == CHAR_NL)
            begin
                return ST_NEWLINE;
            end
        end
        if (cur_row + GLYPH_ROWS >= bottom)
        begin
            text_halted = 1'b1;
            return ST_IGNORED;
        end
        cols = font_columns(c);
        for (int gc = 0; gc < GLYPH_COLS; gc++)
        begin
            for (int gr = 0; gr < GLYPH_ROWS; gr++)
            begin
                if (cols[gc][gr])
                begin
                    set_pixel(cur_col + gc, cur_row + gr, reg_ink);
                end
            end
        end
        cur_col = wrap11(cur_col + CHAR_STEP);
        return ST_GLYPH;
    endfunction

    // apply one item to the shadow state and return its result
    function automatic glyph_result_t render_item(input glyph_item_t it);
        glyph_result_t r;
        r.status    = ST_OTHER;
        r.read_data = '0;
        case (it.kind)
            KIND_TEXT:
            begin
                if (it.text_start)
                begin
                    cur_col     = reg_rx;
                    cur_row     = reg_ry;
                    text_halted = 1'b0;
                end
                r.status = advance_text(it.char_code);
            end
            KIND_PIXEL: set_pixel(int'(it.pixel_x), int'(it.pixel_y), it.pixel_on);
            KIND_READ: r.read_data = shadow_fb[it.byte_index];
            default:
            begin
                foreach (shadow_fb[i])
                begin
                    shadow_fb[i] = '0;
                end
            end
        endcase
        r.cursor_col = cur_col[CUR_W-1:0];
        r.cursor_row = cur_row[CUR_W-1:0];
        return r;
    endfunction

    // item builders
    function automatic glyph_item_t random_fields();
        glyph_item_t it;
        int t;
        it.kind       = $urandom_range(0, 3);
        it.char_code  = $urandom_range(0, 255);
        it.text_start = $urandom_range(0, 1);
        t = int'($urandom_range(0, 383)) - 128;
        it.pixel_x    = t[PIX_W-1:0];
        t = int'($urandom_range(0, 383)) - 128;
        it.pixel_y    = t[PIX_W-1:0];
        it.pixel_on   = $urandom_range(0, 1);
        it.byte_index = $urandom_range(0, FB_BYTES - 1);
        return it;
    endfunction

    function automatic glyph_item_t text_char(input logic [CHAR_W-1:0] c, input bit start);
        glyph_item_t it;
        it = '0;
        it.kind       = KIND_TEXT;
        it.char_code  = c;
        it.text_start = start;
        return it;
    endfunction

    function automatic glyph_item_t pixel_write(input int x, input int y, input bit on);
        glyph_item_t it;
        it = '0;
        it.kind     = KIND_PIXEL;
        it.pixel_x  = x[PIX_W-1:0];
        it.pixel_y  = y[PIX_W-1:0];
        it.pixel_on = on;
        return it;
    endfunction

    function automatic glyph_item_t byte_read(input int idx);
        glyph_item_t it;
        it = '0;
        it.kind       = KIND_READ;
        it.byte_index = idx[BIDX_W-1:0];
        return it;
    endfunction

    // read of a byte close to where text was just drawn
    function automatic glyph_item_t near_cursor_read();
        glyph_item_t it;
        int x;
        int y;
        it = random_fields();
        it.kind = KIND_READ;
        x = cur_col - int'($urandom_range(1, 12));
        y = cur_row + int'($urandom_range(0, 7));
        if (x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT)
        begin
            it.byte_index = (y / 8) * SCREEN_WIDTH + x;
        end
        return it;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            return "A" + $urandom_range(0, 25);
        end
        if (r < 50)
        begin
            return "a" + $urandom_range(0, 25);
        end
        if (r < 65)
        begin
            return "0" + $urandom_range(0, 9);
        end
        if (r < 75)
        begin
            case ($urandom_range(0, 6))
                0: return ".";
                1: return ":";
                2: return "%";
                3: return "-";
                4: return "_";
                5: return "/";
                default: return " ";
            endcase
        end
        if (r < 83)
        begin
            return CHAR_NL;
        end
        return $urandom_range(0, 255);
    endfunction

    // request side: one transfer, with random idle cycles first
    task automatic send_item(input glyph_item_t it);
        glyph_result_t r;
        while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= it.kind;
        req_ch.char_code  <= it.char_code;
        req_ch.text_start <= it.text_start;
        req_ch.pixel_x    <= it.pixel_x;
        req_ch.pixel_y    <= it.pixel_y;
        req_ch.pixel_on   <= it.pixel_on;
        req_ch.byte_index <= it.byte_index;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        r = render_item(it);
        render_outcomes.push_back(r);
        items_sent++;
        if (r.status != ST_IGNORED)
        begin
            counted_items++;
        end
    endtask

    // stop offering items and wait for every outstanding result
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (render_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // apb write: setup then access, register lands at the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_REGION_X: reg_rx = int'($signed(value[8:0]));
            REG_REGION_Y: reg_ry = int'($signed(value[8:0]));
            REG_REGION_W: reg_rw = int'(value[7:0]);
            REG_REGION_H: reg_rh = int'(value[7:0]);
            REG_INK_ON:   reg_ink = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_region(input int rx, input int ry, input int rw, input int rh,
                                input bit ink);
        write_reg(REG_REGION_X, {23'd0, rx[8:0]});
        write_reg(REG_REGION_Y, {23'd0, ry[8:0]});
        write_reg(REG_REGION_W, {24'd0, rw[7:0]});
        write_reg(REG_REGION_H, {24'd0, rh[7:0]});
        write_reg(REG_INK_ON, {31'd0, ink});
        settings_applied++;
    endtask

    // fixed corner settings first, random ones after
    task automatic apply_setting(input int slot);
        case (slot)
            0: apply_region(0, 0, 128, 64, 1'b1);
            1: apply_region(-128, -128, 255, 255, 1'b1);
            2: apply_region(255, 255, 255, 255, 1'b0);
            3: apply_region(-3, -5, 40, 20, 1'b1);
            4: apply_region(110, 50, 30, 30, 1'b1);
            5: apply_region(10, 8, 0, 0, 1'b1);
            6: apply_region(20, 10, 60, 30, 1'b0);
            7: apply_region(0, 0, 255, 255, 1'b1);
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    apply_region(int'($urandom_range(0, 383)) - 128,
                                 int'($urandom_range(0, 383)) - 128,
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 1));
                end
                else
                begin
                    apply_region(int'($urandom_range(0, 100)) - 10,
                                 int'($urandom_range(0, 50)) - 10,
                                 $urandom_range(6, 140), $urandom_range(7, 70),
                                 $urandom_range(0, 3) != 0);
                end
            end
        endcase
    endtask

    // random mix, mostly text runs followed by reads around the cursor
    task automatic run_random(input int target);
        glyph_item_t it;
        int start_count;
        int pick;
        int len;
        start_count = counted_items;
        while (counted_items - start_count < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                begin
                    it = random_fields();
                    it.kind = KIND_TEXT;
                    it.char_code = pick_char();
                    if (i == 0)
                    begin
                        it.text_start = ($urandom_range(0, 9) != 0);
                    end
                    else
                    begin
                        it.text_start = ($urandom_range(0, 49) == 0);
                    end
                    send_item(it);
                end
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    send_item(near_cursor_read());
                end
            end
            else if (pick < 72)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    it = random_fields();
                    it.kind = KIND_PIXEL;
                    if ($urandom_range(0, 4) != 0)
                    begin
                        it.pixel_x = $urandom_range(0, SCREEN_WIDTH - 1);
                        it.pixel_y = $urandom_range(0, SCREEN_HEIGHT - 1);
                    end
                    send_item(it);
                    if (it.pixel_x >= 0 && it.pixel_y >= 0 && it.pixel_x < SCREEN_WIDTH &&
                        it.pixel_y < SCREEN_HEIGHT && $urandom_range(0, 1) == 0)
                    begin
                        send_item(byte_read((int'(it.pixel_y) / 8) * SCREEN_WIDTH +
                                            int'(it.pixel_x)));
                    end
                end
            end
            else if (pick < 86)
            begin
                it = random_fields();
                it.kind = KIND_READ;
                send_item(it);
            end
            else if (pick < 88)
            begin
                it = random_fields();
                it.kind = KIND_CLEAR;
                send_item(it);
            end
            else
            begin
                send_item(random_fields());
            end
        end
    endtask

    // default region: glyph choice, newline, clipped pixels, read and clear
    task automatic test_defaults();
        send_item(byte_read(0));
        send_item(text_char("A", 1'b1));
        send_item(text_char("a", 1'b0));
        send_item(text_char("_", 1'b0));
        send_item(text_char(8'h00, 1'b0));
        send_item(text_char(8'hff, 1'b0));
        send_item(text_char(CHAR_NL, 1'b0));
        send_item(byte_read(13));
        send_item(pixel_write(-128, -128, 1'b1));
        send_item(pixel_write(255, 255, 1'b1));
        send_item(pixel_write(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1'b1));
        send_item(byte_read(FB_BYTES - 1));
        send_item(pixel_write(1, 4, 1'b0));
        send_item(byte_read(1));
        send_item(text_char(8'h41, 1'b1));
        send_item(pixel_write(5, 5, 1'b1));
        send_item(byte_read(5));
        send_item(pixel_write(5, 5, 1'b0));
        send_item(byte_read(5));
        send_item(text_char("%", 1'b0));
        send_item(byte_read(9));
        send_item({KIND_CLEAR, {(CHAR_W + 2 * PIX_W + BIDX_W + 3){1'b1}}});
        send_item(byte_read(0));
    endtask

    // narrow region: width wrap, region full, halt until text start, erase ink
    task automatic test_small_region();
        wait_idle();
        apply_region(4, 2, 12, 16, 1'b1);
        send_item(text_char("B", 1'b1));
        send_item(text_char("C", 1'b0));
        send_item(text_char("D", 1'b0));
        send_item(text_char("E", 1'b0));
        send_item(text_char("F", 1'b0));
        send_item(text_char("G", 1'b0));
        send_item(text_char(CHAR_NL, 1'b0));
        send_item(byte_read(4));
        send_item(byte_read(SCREEN_WIDTH + 4));
        send_item(text_char("1", 1'b1));
        wait_idle();
        write_reg(REG_INK_ON, '0);
        send_item(text_char("8", 1'b1));
        send_item(byte_read(5));
        send_item(byte_read(6));
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        glyph_item_t it;
        wait_idle();
        apply_region(0, 0, 128, 64, 1'b1);
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
        begin
            it = text_char(pick_char(), i == 0);
            if (i % 5 == 4)
            begin
                it = near_cursor_read();
            end
            send_item(it);
        end
        wait_idle();
    endtask

    task automatic test_region_sweep(input int req_pct, input int rsp_pct, input int mode);
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        for (int s = 0; s < 5; s++)
        begin
            wait_idle();
            apply_setting(mode * 5 + s);
            run_random(115);
        end
    endtask

    // result side ready, with random stalls and the long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input integer expected, input integer actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            errors++;
        end
    endtask

    // compare each result transfer with the oldest outstanding prediction
    initial
    begin
        glyph_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (render_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: status %0d", rsp_ch.status);
                    errors++;
                end
                else
                begin
                    exp_r = render_outcomes.pop_front();
                    check_field("status", exp_r.status, rsp_ch.status);
                    check_field("read_data", exp_r.read_data, rsp_ch.read_data);
                    check_field("cursor_col", exp_r.cursor_col, rsp_ch.cursor_col);
                    check_field("cursor_row", exp_r.cursor_row, rsp_ch.cursor_row);
                    case (exp_r.status)
                        ST_GLYPH:   n_glyph++;
                        ST_NEWLINE: n_newline++;
                        ST_IGNORED: n_ignored++;
                        default:    n_other++;
                    endcase
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, render_outcomes.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_TEXT;
        req_ch.char_code  = '0;
        req_ch.text_start = 1'b0;
        req_ch.pixel_x    = '0;
        req_ch.pixel_y    = '0;
        req_ch.pixel_on   = 1'b0;
        req_ch.byte_index = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        foreach (shadow_fb[i])
        begin
            shadow_fb[i] = '0;
        end
        cur_col = 0;
        cur_row = 0;
        text_halted = 1'b0;
        reg_rx  = 0;
        reg_ry  = 0;
        reg_rw  = 128;
        reg_rh  = 64;
        reg_ink = 1'b1;
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        hold_left = 0;
        errors = 0;
        items_sent = 0;
        counted_items = 0;
        settings_applied = 0;
        n_glyph = 0;
        n_newline = 0;
        n_ignored = 0;
        n_other = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_small_region();
        test_output_backpressure();
        test_region_sweep(20, 85, 0);
        test_region_sweep(85, 20, 1);
        test_region_sweep(0, 0, 2);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items over %0d register settings: %0d glyphs, %0d newlines,",
                 items_sent, settings_applied, n_glyph, n_newline);
        $display("%0d ignored characters, %0d pixel/read/clear results, with idling, stalls and a long hold-off",
                 n_ignored, n_other);
        if (errors == 0 && render_outcomes.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
